// ===== hdl/wlcm_pkg.sv =====
// Shared types, constants and helper functions of the window-level color mapper.
`timescale 1ns / 1ps
`default_nettype none
package wlcm_pkg;

   localparam int MAX_COLORS     = 256;
   localparam int COLOR_BITS     = 8;
   localparam int SAMPLE_BITS    = 16;
   localparam int MAP_ADDR_BITS  = 16;
   localparam int MAP_DEPTH      = 65536;
   localparam int WIDTH_BITS     = 15;
   localparam int COUNT_BITS     = 9;
   localparam int NUM_BITS       = COLOR_BITS + WIDTH_BITS;
   localparam int RGBA_BITS      = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef enum logic [1:0] {
      MODE_MAP         = 2'd0,
      MODE_LOAD_COLOR  = 2'd1,
      MODE_LOAD_DIRECT = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_WIDTH     = 3'd0,
      CSR_WINDOW_CENTER    = 3'd1,
      CSR_LOWER_THRESHOLD  = 3'd2,
      CSR_UPPER_THRESHOLD  = 3'd3,
      CSR_THRESHOLD_ENABLE = 3'd4,
      CSR_DIRECT_SELECT    = 3'd5,
      CSR_FMRI_SELECT      = 3'd6,
      CSR_COLOR_COUNT      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_MAP,
      OP_COLOR,
      OP_DIRECT
   } op_type;

   typedef enum logic [1:0] {
      RAMP_LOW,
      RAMP_HIGH,
      RAMP_MID
   } ramp_case_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]         window_width;
      logic signed [SAMPLE_BITS-1:0] window_center;
      logic signed [SAMPLE_BITS-1:0] lower_threshold;
      logic signed [SAMPLE_BITS-1:0] upper_threshold;
      logic                          threshold_enable;
      logic                          direct_select;
      logic                          fmri_select;
      logic [COUNT_BITS-1:0]         color_count;
   } cfg_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [COLOR_BITS-1:0]         entry_index;
      logic [RGBA_BITS-1:0]          entry_rgba;
      logic                          last_in;
   } req_type;

   typedef struct packed {
      logic [RGBA_BITS-1:0]  pixel_rgba;
      logic [COLOR_BITS-1:0] color_index;
      logic                  last_out;
   } rsp_type;

   // One classified request as it waits between the front and back ends.
   typedef struct packed {
      op_type                  op;
      logic [MAP_ADDR_BITS-1:0] map_addr;
      logic [COLOR_BITS-1:0]   entry_index;
      logic [RGBA_BITS-1:0]    rgba;
      logic                    last;
      ramp_case_type           ramp;
      logic [WIDTH_BITS-1:0]   offset;
      logic                    reject;
   } item_type;

   // Divisor of the ramp: the window width, but never below two.
   function automatic logic [WIDTH_BITS-1:0] ramp_divisor(input logic [WIDTH_BITS-1:0] w);
      ramp_divisor = (w < WIDTH_BITS'(2)) ? WIDTH_BITS'(2) : w;
   endfunction

   // Highest ramp index: color count saturated into [2, MAX_COLORS], minus one.
   function automatic logic [COLOR_BITS-1:0] color_top(input logic [COUNT_BITS-1:0] c);
      if (c < COUNT_BITS'(2)) begin
         color_top = COLOR_BITS'(1);
      end else if (c > COUNT_BITS'(MAX_COLORS)) begin
         color_top = COLOR_BITS'(MAX_COLORS - 1);
      end else begin
         color_top = COLOR_BITS'(c - COUNT_BITS'(1));
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/wlcm_front.sv =====
// Front end: accepts requests, classifies them and evaluates ramp case and thresholds.
`timescale 1ns / 1ps
`default_nettype none
module wlcm_front (
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wlcm_pkg::req_type      req_data,
   input  wlcm_pkg::cfg_type      cfg,
   input  wire                    queue_full,
   input  wire                    clear_done,
   output logic                   push,
   output wlcm_pkg::item_type     item
);

   logic signed [17:0] s;
   logic signed [17:0] lo;
   logic signed [17:0] hi;
   logic signed [17:0] lw;
   logic signed [17:0] up;
   logic signed [17:0] h;
   logic signed [17:0] l;
   logic signed [17:0] sa;
   logic signed [17:0] diff;
   logic               rej;
   logic               keep;

   // Requests are taken once the map is cleared and the queue has room.
   assign req_ready = clear_done && !queue_full;

   // Ramp bounds from the window registers.
   always_comb begin
      s    = 18'(req_data.sample);
      lo   = 18'(cfg.window_center) - $signed({3'b000, cfg.window_width[14:1]});
      hi   = lo + $signed({3'b000, wlcm_pkg::ramp_divisor(cfg.window_width)}) - 18'sd1;
      diff = s - lo;
   end

   // Threshold band test.
   always_comb begin
      lw = 18'(cfg.lower_threshold);
      up = 18'(cfg.upper_threshold);
      h  = (up < 0) ? -up : up;
      l  = (lw < 0) ? -lw : lw;
      sa = (s < 0) ? -s : s;
      if (cfg.fmri_select) begin
         rej = (lw > up) || (s > h) || (s < -h) || (sa < l);
      end else if (lw <= up) begin
         rej = (s < lw) || (s > up);
      end else begin
         rej = (s >= up) && (s <= lw);
      end
   end

   // Classification of the request into a queue item.
   always_comb begin
      keep = 1'b1;
      item.op = wlcm_pkg::OP_MAP;
      case (req_data.mode)
         wlcm_pkg::MODE_MAP:         item.op = wlcm_pkg::OP_MAP;
         wlcm_pkg::MODE_LOAD_COLOR:  item.op = wlcm_pkg::OP_COLOR;
         wlcm_pkg::MODE_LOAD_DIRECT: item.op = wlcm_pkg::OP_DIRECT;
         default:                    keep = 1'b0;
      endcase
      item.map_addr    = {~req_data.sample[15], req_data.sample[14:0]};
      item.entry_index = req_data.entry_index;
      item.rgba        = req_data.entry_rgba;
      item.last        = req_data.last_in;
      item.offset      = diff[14:0];
      item.reject      = cfg.threshold_enable && rej;
      if (s <= lo) begin
         item.ramp = wlcm_pkg::RAMP_LOW;
      end else if (s >= hi) begin
         item.ramp = wlcm_pkg::RAMP_HIGH;
      end else begin
         item.ramp = wlcm_pkg::RAMP_MID;
      end
      push = req_valid && req_ready && keep;
   end

endmodule
`default_nettype wire

// ===== hdl/wlcm_queue.sv =====
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module wlcm_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  wlcm_pkg::item_type  push_item,
   input  wire                 pop,
   output wlcm_pkg::item_type  head,
   output logic                empty,
   output logic                full
);

   localparam int PB = wlcm_pkg::QUEUE_PTR_BITS;

   wlcm_pkg::item_type    slot_ff [wlcm_pkg::QUEUE_DEPTH];
   logic [PB-1:0]         wr_ptr_ff;
   logic [PB-1:0]         wr_ptr_in;
   logic [PB-1:0]         rd_ptr_ff;
   logic [PB-1:0]         rd_ptr_in;
   logic [PB:0]           count_ff;
   logic [PB:0]           count_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PB+1)'(wlcm_pkg::QUEUE_DEPTH));

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff + (PB+1)'(push) - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/wlcm_back.sv =====
// Back end: direct map memory, ramp multiply and divide pipeline, color table and output.
`timescale 1ns / 1ps
`default_nettype none
module wlcm_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wlcm_pkg::cfg_type   cfg,
   input  wlcm_pkg::item_type  head,
   input  wire                 queue_empty,
   output logic                pop,
   output logic                clear_done,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output wlcm_pkg::rsp_type   rsp_data
);

   localparam int CB     = wlcm_pkg::COLOR_BITS;
   localparam int NB     = wlcm_pkg::NUM_BITS;
   localparam int AB     = wlcm_pkg::MAP_ADDR_BITS;
   localparam int STAGES = CB + 1;

   typedef struct packed {
      logic                    valid;
      wlcm_pkg::op_type        op;
      wlcm_pkg::ramp_case_type ramp;
      logic                    reject;
      logic                    last;
      logic [CB-1:0]           entry_index;
      logic [wlcm_pkg::RGBA_BITS-1:0] rgba;
      logic [CB-1:0]           map_idx;
      logic [NB-1:0]           rem;
      logic [CB-1:0]           quot;
   } pipe_type;

   logic [CB-1:0]              direct_mem [wlcm_pkg::MAP_DEPTH];
   logic [wlcm_pkg::RGBA_BITS-1:0] color_mem [wlcm_pkg::MAX_COLORS];

   pipe_type                   pipe_ff [STAGES];
   pipe_type                   pipe_in [STAGES];
   logic [CB-1:0]              direct_rd_ff;
   logic [wlcm_pkg::RGBA_BITS-1:0] color_rd_ff;
   logic                       out_valid_ff;
   logic [CB-1:0]              out_idx_ff;
   logic                       out_last_ff;
   logic [AB:0]                clear_cnt_ff;
   logic [AB:0]                clear_cnt_in;
   logic                       advance;
   logic [wlcm_pkg::WIDTH_BITS-1:0] divisor;
   logic [CB-1:0]              top_idx;
   logic [CB-1:0]              final_idx;
   logic [NB-1:0]              trial;
   pipe_type                   last_stage;

   assign clear_done = clear_cnt_ff[AB];
   assign advance    = !out_valid_ff || rsp_ready;
   assign pop        = advance && !queue_empty && clear_done;
   assign divisor    = wlcm_pkg::ramp_divisor(cfg.window_width);
   assign top_idx    = wlcm_pkg::color_top(cfg.color_count);
   assign last_stage = pipe_ff[STAGES-1];

   // Clearing pass over the direct map after reset.
   assign clear_cnt_in = clear_done ? clear_cnt_ff : clear_cnt_ff + (AB+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Direct map: cleared to one, written by direct loads, read when an item enters.
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         direct_mem[clear_cnt_ff[AB-1:0]] <= CB'(1);
      end else if (pop && head.op == wlcm_pkg::OP_DIRECT) begin
         direct_mem[head.map_addr] <= head.entry_index;
      end
      if (advance) begin
         direct_rd_ff <= direct_mem[head.map_addr];
      end
   end

   // Entry stage with the ramp product, then one quotient bit per stage.
   always_comb begin
      pipe_in[0].valid       = pop && head.op != wlcm_pkg::OP_DIRECT;
      pipe_in[0].op          = head.op;
      pipe_in[0].ramp        = head.ramp;
      pipe_in[0].reject      = head.reject;
      pipe_in[0].last        = head.last;
      pipe_in[0].entry_index = head.entry_index;
      pipe_in[0].rgba        = head.rgba;
      pipe_in[0].map_idx     = '0;
      pipe_in[0].rem         = NB'(top_idx) * NB'(head.offset);
      pipe_in[0].quot        = '0;
      trial = '0;
      for (int k = 1; k < STAGES; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         if (k == 1) begin
            pipe_in[k].map_idx = direct_rd_ff;
         end
         trial = NB'(divisor) << (CB - k);
         if (pipe_ff[k-1].rem >= trial) begin
            pipe_in[k].rem          = pipe_ff[k-1].rem - trial;
            pipe_in[k].quot[CB - k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Final color index selection.
   always_comb begin
      if (cfg.direct_select) begin
         final_idx = last_stage.map_idx;
      end else begin
         case (last_stage.ramp)
            wlcm_pkg::RAMP_LOW:  final_idx = CB'(1);
            wlcm_pkg::RAMP_HIGH: final_idx = top_idx;
            default:             final_idx = last_stage.quot + CB'(1);
         endcase
      end
      if (last_stage.reject) begin
         final_idx = '0;
      end
   end

   // Color table: loads and lookups at the same stage keep request order.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (last_stage.valid && last_stage.op == wlcm_pkg::OP_COLOR &&
             last_stage.entry_index != '0) begin
            color_mem[last_stage.entry_index] <= last_stage.rgba;
         end
         color_rd_ff <= color_mem[final_idx];
         out_idx_ff  <= final_idx;
         out_last_ff <= last_stage.last;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last_stage.valid && last_stage.op == wlcm_pkg::OP_MAP;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_data.pixel_rgba  = (out_idx_ff == '0) ? '0 : color_rd_ff;
   assign rsp_data.color_index = out_idx_ff;
   assign rsp_data.last_out    = out_last_ff;

endmodule
`default_nettype wire

// ===== hdl/window_level_threshold_color_map_core.sv =====
// Top level of the window-level threshold color mapper with its control registers.
`timescale 1ns / 1ps
`default_nettype none
// Maps signed 16-bit samples to RGBA colors, one request per clock once running and
// while the queue has room and no stalled response holds the pipeline. After reset
// the block sets every direct map entry to one, one entry per cycle, and holds
// req_ready low meanwhile; register writes are taken throughout. A map request goes
// through the request queue into the entry stage, which reads the direct map and
// forms the ramp product, then through the restoring divider that produces one
// quotient bit per stage, then through the color table read and the output register.
// A stalled response holds the whole pipeline. Load requests produce no response.
// Registers should be written only while no request is in flight.
module window_level_threshold_color_map_core (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_ready,
   input  wlcm_pkg::req_type                          req_data,
   output logic                                       rsp_valid,
   input  wire                                        rsp_ready,
   output wlcm_pkg::rsp_type                          rsp_data,
   input  wire                                        csr_write_enable,
   input  wire [wlcm_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  wire [wlcm_pkg::CSR_DATA_BITS-1:0]          csr_write_data
);

   wlcm_pkg::cfg_type  cfg_ff;
   wlcm_pkg::cfg_type  cfg_in;
   wlcm_pkg::item_type front_item;
   wlcm_pkg::item_type queue_head;
   logic               push;
   logic               pop;
   logic               queue_empty;
   logic               queue_full;
   logic               clear_done;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (wlcm_pkg::csr_index_type'(csr_index))
            wlcm_pkg::CSR_WINDOW_WIDTH:     cfg_in.window_width = csr_write_data[14:0];
            wlcm_pkg::CSR_WINDOW_CENTER:    cfg_in.window_center = csr_write_data;
            wlcm_pkg::CSR_LOWER_THRESHOLD:  cfg_in.lower_threshold = csr_write_data;
            wlcm_pkg::CSR_UPPER_THRESHOLD:  cfg_in.upper_threshold = csr_write_data;
            wlcm_pkg::CSR_THRESHOLD_ENABLE: cfg_in.threshold_enable = csr_write_data[0];
            wlcm_pkg::CSR_DIRECT_SELECT:    cfg_in.direct_select = csr_write_data[0];
            wlcm_pkg::CSR_FMRI_SELECT:      cfg_in.fmri_select = csr_write_data[0];
            wlcm_pkg::CSR_COLOR_COUNT:      cfg_in.color_count = csr_write_data[8:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_width     <= 15'd256;
         cfg_ff.window_center    <= 16'sd128;
         cfg_ff.lower_threshold  <= -16'sd32768;
         cfg_ff.upper_threshold  <= 16'sd32767;
         cfg_ff.threshold_enable <= 1'b1;
         cfg_ff.direct_select    <= 1'b0;
         cfg_ff.fmri_select      <= 1'b0;
         cfg_ff.color_count      <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wlcm_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .clear_done (clear_done),
      .push       (push),
      .item       (front_item)
   );

   wlcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head      (queue_head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   wlcm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (queue_head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .clear_done  (clear_done),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hdl/wlcm_checker.sv =====
// Port-level checks of the color mapper and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wlcm_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wlcm_pkg::rsp_type rsp_data
);

   // No response and no request taken right after reset.
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("block not idle after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Index zero always shows transparent black.
   a_zero_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.color_index == '0 |-> rsp_data.pixel_rgba == '0)
      else $error("thresholded sample not transparent");

   // The map clearing pass keeps requests out as reset is released.
   a_clear_holds: assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind window_level_threshold_color_map_core wlcm_checker u_wlcm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== bench/tb_window_level_threshold_color_map_core.sv =====
// Self-checking testbench for the window-level threshold color mapper core.
`timescale 1ns / 1ps
module tb_window_level_threshold_color_map_core;

   localparam wlcm_pkg::mode_type MODE_UNUSED = wlcm_pkg::mode_type'(2'd3);
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 115;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   wlcm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   wlcm_pkg::rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [wlcm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [wlcm_pkg::CSR_DATA_BITS-1:0] csr_write_data = '0;

   // Shadow copy of the registers and tables as the block should hold them.
   int cfg_width, cfg_center, cfg_lower, cfg_upper, cfg_count;
   bit cfg_thresh, cfg_direct, cfg_fmri;
   logic [wlcm_pkg::RGBA_BITS-1:0] color_shadow [wlcm_pkg::MAX_COLORS];
   logic [wlcm_pkg::COLOR_BITS-1:0] direct_shadow [wlcm_pkg::MAP_DEPTH];

   wlcm_pkg::rsp_type pending_pixels[$];
   int typed_index = -1;
   int fail_count = 0;
   int map_count = 0;
   int load_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   window_level_threshold_color_map_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Window-level ramp index for one sample under the current registers.
   function automatic int ramp_position(int s);
      longint n, lo, hi;
      n = cfg_count;
      if (n < 2) n = 2;
      if (n > wlcm_pkg::MAX_COLORS) n = wlcm_pkg::MAX_COLORS;
      lo = longint'(cfg_center) - longint'(cfg_width / 2);
      hi = lo + cfg_width - 1;
      if (hi <= lo) hi = lo + 1;
      if (s <= lo) return 1;
      if (s >= hi) return int'(n - 1);
      return int'(1 + ((n - 1) * (s - lo)) / (hi - lo + 1));
   endfunction

   // True when thresholding sends the sample to the transparent entry.
   function automatic bit thresholded_out(int s);
      int h, l, m;
      if (!cfg_thresh) return 1'b0;
      if (cfg_fmri) begin
         h = (cfg_upper < 0) ? -cfg_upper : cfg_upper;
         l = (cfg_lower < 0) ? -cfg_lower : cfg_lower;
         m = (s < 0) ? -s : s;
         if (cfg_lower > cfg_upper) return 1'b1;
         return s > h || s < -h || m < l;
      end
      if (cfg_lower <= cfg_upper) return s < cfg_lower || s > cfg_upper;
      return s >= cfg_upper && s <= cfg_lower;
   endfunction

   function automatic wlcm_pkg::rsp_type lookup_color(int idx, logic last);
      wlcm_pkg::rsp_type r;
      r.color_index = wlcm_pkg::COLOR_BITS'(idx);
      r.pixel_rgba = (idx != 0) ? color_shadow[idx] : '0;
      r.last_out = last;
      return r;
   endfunction

   // Track every accepted request in the shadow state and queue the expected pixel.
   always @(posedge clock) begin
      int s, idx;
      if (!reset && req_valid && req_ready) begin
         s = int'(req_data.sample);
         case (req_data.mode)
            wlcm_pkg::MODE_LOAD_COLOR: begin
               if (req_data.entry_index != 0)
                  color_shadow[req_data.entry_index] = req_data.entry_rgba;
               load_count++;
            end
            wlcm_pkg::MODE_LOAD_DIRECT: begin
               direct_shadow[{~req_data.sample[15], req_data.sample[14:0]}] =
                  req_data.entry_index;
               load_count++;
            end
            wlcm_pkg::MODE_MAP: begin
               if (cfg_direct) idx = direct_shadow[{~req_data.sample[15], req_data.sample[14:0]}];
               else idx = ramp_position(s);
               if (thresholded_out(s)) idx = 0;
               if (typed_index >= 0) idx = typed_index;
               pending_pixels.push_back(lookup_color(idx, req_data.last_in));
               map_count++;
            end
            default: ;
         endcase
      end
   end

   // Compare each accepted response with the oldest expected pixel.
   always @(posedge clock) begin
      wlcm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_rgba !== want.pixel_rgba) begin
               $error("pixel_rgba expected %h actual %h", want.pixel_rgba, rsp_data.pixel_rgba);
               fail_count++;
            end
            if (rsp_data.color_index !== want.color_index) begin
               $error("color_index expected %0d actual %0d", want.color_index,
                      rsp_data.color_index);
               fail_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out expected %0d actual %0d", want.last_out, rsp_data.last_out);
               fail_count++;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Present one request, with optional idle gaps, and return after acceptance.
   task automatic send_request(input wlcm_pkg::req_type r, input int typed);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      typed_index <= typed;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Wait until every expected pixel has come back, then let the pipeline empty.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input wlcm_pkg::csr_index_type idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= wlcm_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
   endtask

   // Program all eight registers and mirror them in the shadow copy.
   task automatic apply_settings(input int w, input int c, input int lo, input int up,
                                 input bit te, input bit ds, input bit fs, input int cc);
      write_register(wlcm_pkg::CSR_WINDOW_WIDTH, w);
      write_register(wlcm_pkg::CSR_WINDOW_CENTER, c);
      write_register(wlcm_pkg::CSR_LOWER_THRESHOLD, lo);
      write_register(wlcm_pkg::CSR_UPPER_THRESHOLD, up);
      write_register(wlcm_pkg::CSR_THRESHOLD_ENABLE, te);
      write_register(wlcm_pkg::CSR_DIRECT_SELECT, ds);
      write_register(wlcm_pkg::CSR_FMRI_SELECT, fs);
      write_register(wlcm_pkg::CSR_COLOR_COUNT, cc);
      csr_write_enable <= 1'b0;
      cfg_width = w & 16'h7FFF;
      cfg_center = int'(16'(c) ^ 16'h8000) - 32768;
      cfg_lower = int'(16'(lo) ^ 16'h8000) - 32768;
      cfg_upper = int'(16'(up) ^ 16'h8000) - 32768;
      cfg_thresh = te;
      cfg_direct = ds;
      cfg_fmri = fs;
      cfg_count = cc & 16'h1FF;
   endtask

   function automatic wlcm_pkg::req_type make_request(wlcm_pkg::mode_type m, int s, int idx,
                                                      logic [31:0] rgba, logic last);
      wlcm_pkg::req_type r;
      r.mode = m;
      r.sample = 16'(s);
      r.entry_index = 8'(idx);
      r.entry_rgba = rgba;
      r.last_in = last;
      return r;
   endfunction

   // Random sample, mostly around the window, sometimes anywhere or at an extreme.
   function automatic int pick_sample();
      int k;
      k = $urandom_range(9);
      if (k == 0) return ($urandom_range(1) != 0) ? 32767 : -32768;
      if (k < 4) return int'($urandom_range(65535)) - 32768;
      k = cfg_center + int'($urandom_range(cfg_width + 8)) - (cfg_width + 8) / 2;
      if (k > 32767) k = 32767;
      if (k < -32768) k = -32768;
      return k;
   endfunction

   typedef struct {
      wlcm_pkg::req_type r;
      int typed;
   } stimulus_row;

   stimulus_row directed_rows[$];

   initial begin
      wlcm_pkg::req_type r;
      int pick, s;
      for (int i = 0; i < wlcm_pkg::MAP_DEPTH; i++) direct_shadow[i] = 8'd1;
      for (int i = 0; i < wlcm_pkg::MAX_COLORS; i++) color_shadow[i] = '0;
      cfg_width = 256; cfg_center = 128; cfg_lower = -32768; cfg_upper = 32767;
      cfg_thresh = 1'b1; cfg_direct = 1'b0; cfg_fmri = 1'b0; cfg_count = 256;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Fill color table entries 1 to 255 first so no unwritten entry is ever shown.
      for (int i = 1; i < wlcm_pkg::MAX_COLORS; i++)
         send_request(make_request(wlcm_pkg::MODE_LOAD_COLOR, 0, i, $urandom(), 1'b0), -1);

      // Directed rows under the reset settings: ramp from 0 to 255, full threshold band.
      directed_rows = '{
         '{make_request(wlcm_pkg::MODE_MAP, -32768, 0, 0, 1'b0), 1},
         '{make_request(wlcm_pkg::MODE_MAP, 32767, 0, 0, 1'b1), 255},
         '{make_request(wlcm_pkg::MODE_MAP, 0, 0, 0, 1'b0), 1},
         '{make_request(wlcm_pkg::MODE_MAP, 255, 0, 0, 1'b1), 255},
         '{make_request(wlcm_pkg::MODE_MAP, 128, 0, 0, 1'b0), -1},
         '{make_request(wlcm_pkg::MODE_MAP, 1, 0, 0, 1'b0), -1},
         '{make_request(wlcm_pkg::MODE_MAP, 254, 0, 0, 1'b0), -1},
         '{make_request(MODE_UNUSED, 77, 9, 32'hFFFF_FFFF, 1'b1), -1},
         '{make_request(wlcm_pkg::MODE_LOAD_COLOR, 0, 0, 32'hFFFF_FFFF, 1'b1), -1},
         '{make_request(wlcm_pkg::MODE_LOAD_COLOR, -1, 255, 32'hFFFF_FFFF, 1'b1), -1},
         '{make_request(wlcm_pkg::MODE_LOAD_COLOR, 32767, 1, 32'h0000_0000, 1'b0), -1},
         '{make_request(wlcm_pkg::MODE_MAP, 32767, 0, 0, 1'b0), 255},
         '{make_request(wlcm_pkg::MODE_MAP, -32768, 0, 0, 1'b1), 1},
         '{make_request(wlcm_pkg::MODE_LOAD_DIRECT, -32768, 0, 32'hFFFF_FFFF, 1'b1), -1},
         '{make_request(wlcm_pkg::MODE_LOAD_DIRECT, 32767, 255, 0, 1'b0), -1},
         '{make_request(wlcm_pkg::MODE_LOAD_DIRECT, 0, 128, 0, 1'b0), -1},
         '{make_request(wlcm_pkg::MODE_MAP, 100, 0, 0, 1'b1), -1}
      };
      foreach (directed_rows[i]) send_request(directed_rows[i].r, directed_rows[i].typed);
      drain_pipeline();

      // Direct map after the loads above, with thresholding off.
      apply_settings(256, 128, -32768, 32767, 1'b0, 1'b1, 1'b0, 256);
      send_request(make_request(wlcm_pkg::MODE_MAP, -32768, 0, 0, 1'b0), 0);
      send_request(make_request(wlcm_pkg::MODE_MAP, 32767, 0, 0, 1'b1), 255);
      send_request(make_request(wlcm_pkg::MODE_MAP, 5, 0, 0, 1'b0), 1);
      drain_pipeline();

      // Thresholding with a band of [10, 20] must reject samples outside it.
      apply_settings(256, 128, 10, 20, 1'b1, 1'b0, 1'b0, 256);
      send_request(make_request(wlcm_pkg::MODE_MAP, 9, 0, 0, 1'b0), 0);
      send_request(make_request(wlcm_pkg::MODE_MAP, 21, 0, 0, 1'b1), 0);
      drain_pipeline();

      // Random phases, each under its own register settings and one of four idling patterns.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(256, 128, -32768, 32767, 1'b1, 1'b0, 1'b0, 256);
            1: apply_settings(1, -32768, 32767, -32768, 1'b1, 1'b0, 1'b0, 0);
            2: apply_settings(32767, 32767, -100, 100, 1'b1, 1'b0, 1'b1, 511);
            3: apply_settings(64, 0, 0, 0, 1'b0, 1'b1, 1'b0, 2);
            4: apply_settings(0, 0, 40, -40, 1'b1, 1'b0, 1'b1, 1);
            default: apply_settings($urandom_range(1) ? $urandom_range(32767)
                                                      : $urandom_range(600),
                                    $urandom_range(65535), $urandom_range(65535),
                                    $urandom_range(65535), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    $urandom_range(511));
         endcase
         sender_idle_pct = (p % 4 == 1) ? 53 : (p % 4 == 3) ? 35 : 0;
         receiver_stall_pct = (p % 4 == 2) ? 53 : (p % 4 == 3) ? 35 : 0;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Once, hold the sender back until every outstanding pixel is out.
            if (p == 2 && i == ITEMS_PER_PHASE / 2) drain_pipeline();
            pick = $urandom_range(99);
            s = pick_sample();
            if (pick < 70)
               r = make_request(wlcm_pkg::MODE_MAP, s, $urandom(), $urandom(),
                                1'($urandom()));
            else if (pick < 82)
               r = make_request(wlcm_pkg::MODE_LOAD_COLOR, $urandom(), $urandom_range(255),
                                $urandom(), 1'($urandom()));
            else if (pick < 94)
               r = make_request(wlcm_pkg::MODE_LOAD_DIRECT, s, $urandom_range(255),
                                $urandom(), 1'($urandom()));
            else r = make_request(MODE_UNUSED, $urandom(), $urandom(), $urandom(),
                                  1'($urandom()));
            send_request(r, -1);
         end
         drain_pipeline();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      $display("Covered %0d mapped samples and %0d table loads over %0d register settings,",
               map_count, load_count, RANDOM_PHASES + 3);
      $display("with ramp, direct, normal and symmetric thresholding under varied idling.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/wlcm_pkg.sv
hdl/wlcm_front.sv
hdl/wlcm_queue.sv
hdl/wlcm_back.sv
hdl/window_level_threshold_color_map_core.sv
hdl/wlcm_checker.sv
bench/tb_window_level_threshold_color_map_core.sv
